// ===== design/cpts_pkg.sv =====
// Shared types and constants of the counter priority task scheduler.
package cpts_pkg;

    // Widths of the word fields at the ports.
    localparam int OP_W          = 2;
    localparam int SLOT_FIELD_W  = 6;
    localparam int VALUE_FIELD_W = 8;
    localparam int TASK_FIELD_W  = 6;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 2'd0,
        OP_SETRUN = 2'd1,
        OP_TICK   = 2'd2,
        OP_SCHED  = 2'd3
    } t_op;

    // Kind of pass that a packet performs as it walks down the chain.
    typedef enum logic [1:0] {
        PASS_TICK   = 2'd0,
        PASS_SCAN   = 2'd1,
        PASS_RELOAD = 2'd2
    } t_pass;

    // Control part of the packet handed from cell to cell.
    typedef struct packed {
        logic  valid;
        t_pass mode;
        logic  hit;
        logic  user;
    } t_ctl;

    // Slot update broadcast to every cell.
    typedef struct packed {
        logic en;
        logic full;
        logic present;
        logic runnable;
    } t_wr;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_SCAN,
        S_RELOAD,
        S_DONE
    } t_state;

endpackage

// ===== design/cpts_cell.sv =====
// One task slot of the scheduler chain, with its stage of the pass packet.
module cpts_cell
    import cpts_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int SLOT_BITS  = 6,
    parameter int COUNT_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_wr                   i_wr,
    input  logic [SLOT_BITS-1:0]  i_wr_slot,
    input  logic [COUNT_BITS-1:0] i_wr_priority,
    input  logic [COUNT_BITS-1:0] i_wr_counter,
    input  logic [SLOT_BITS-1:0]  i_cur,
    input  t_ctl                  i_ctl,
    input  logic [COUNT_BITS-1:0] i_best,
    input  logic [SLOT_BITS-1:0]  i_pick,
    output t_ctl                  o_ctl,
    output logic [COUNT_BITS-1:0] o_best,
    output logic [SLOT_BITS-1:0]  o_pick
);

    localparam logic [SLOT_BITS-1:0] SELF = SLOT_BITS'(IDX);

    logic                  r_present, n_present;
    logic                  r_runnable, n_runnable;
    logic [COUNT_BITS-1:0] r_priority, n_priority;
    logic [COUNT_BITS-1:0] r_counter, n_counter;
    t_ctl                  r_ctl, n_ctl;
    logic [COUNT_BITS-1:0] r_best, n_best;
    logic [SLOT_BITS-1:0]  r_pick, n_pick;
    logic [COUNT_BITS-1:0] w_cand;
    logic [COUNT_BITS-1:0] w_dec;

    assign w_cand = (i_ctl.mode == PASS_RELOAD) ? r_priority : r_counter;
    assign w_dec  = (r_counter == '0) ? '0 : r_counter - COUNT_BITS'(1);

    always_comb begin
        n_present  = r_present;
        n_runnable = r_runnable;
        n_priority = r_priority;
        n_counter  = r_counter;
        n_ctl      = i_ctl;
        n_best     = i_best;
        n_pick     = i_pick;

        if (i_wr.en && i_wr_slot == SELF) begin
            n_runnable = i_wr.runnable;
            if (i_wr.full) begin
                n_present  = i_wr.present;
                n_priority = i_wr_priority;
                n_counter  = i_wr_counter;
            end
        end

        if (i_ctl.valid) begin
            unique case (i_ctl.mode)
                PASS_TICK: begin
                    if (i_cur == SELF && r_present) begin
                        n_counter = w_dec;
                        if (w_dec == '0) begin
                            if (i_ctl.user) begin
                                n_ctl.hit = 1'b1;
                            end else begin
                                n_counter = COUNT_BITS'(1);
                            end
                        end
                    end
                end
                PASS_SCAN, PASS_RELOAD: begin
                    if (i_ctl.mode == PASS_RELOAD && r_present) begin
                        n_counter = r_priority;
                    end
                    if (r_present && r_runnable && w_cand > i_best) begin
                        n_best = w_cand;
                        n_pick = SELF;
                    end
                end
                default: begin
                    n_ctl.valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= 1'b0;
            r_ctl     <= '0;
        end else begin
            r_present <= n_present;
            r_ctl     <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_runnable <= n_runnable;
        r_priority <= n_priority;
        r_counter  <= n_counter;
        r_best     <= n_best;
        r_pick     <= n_pick;
    end

    assign o_ctl  = r_ctl;
    assign o_best = r_best;
    assign o_pick = r_pick;

endmodule

// ===== design/counter_priority_task_scheduler.sv =====
// Top level of the counter priority task scheduler: pass control and the chain of slot cells.
//
// The task table lives in a chain of SLOTS identical cells, one slot per cell. Write slot and
// set runnable words are broadcast to the addressed cell; their result word is ready on the
// next cycle. A timer tick and a schedule are carried out by a packet that the controller
// launches at the head of the chain and that moves one cell per clock. The result register is
// loaded after the last pass, once the output is free. A schedule takes one pass, or two when
// every runnable counter is zero and the second pass reloads the counters from the priorities
// while it scans. A tick takes one pass to reach the current slot and report whether its slice
// ran out in user mode, plus the schedule passes in that case. The scheduler works on one word
// at a time and takes the next input word as soon as the result register is free or being
// emptied. Slot indexes at or above SLOTS are ignored by writes. Present flags clear on reset;
// all other slot fields must be written before they are used, which a write slot always does.
module counter_priority_task_scheduler
    import cpts_pkg::*;
#(
    parameter int SLOTS      = 64,
    parameter int COUNT_BITS = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [OP_W-1:0]          i_operation,
    input  logic [SLOT_FIELD_W-1:0]  i_slot,
    input  logic                     i_present,
    input  logic                     i_runnable,
    input  logic [VALUE_FIELD_W-1:0] i_priority_req,
    input  logic [VALUE_FIELD_W-1:0] i_counter,
    input  logic                     i_user_mode,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [TASK_FIELD_W-1:0]  o_current_task,
    output logic                     o_switched,
    output logic                     o_scheduled,
    output logic                     o_idle_fallback
);

    localparam int SLOT_BITS = $clog2(SLOTS);

    // Chain taps: index 0 is the head driven here, index SLOTS is the tail.
    t_ctl                  w_ctl  [0:SLOTS];
    logic [COUNT_BITS-1:0] w_best [0:SLOTS];
    logic [SLOT_BITS-1:0]  w_pick [0:SLOTS];

    t_state                r_state, n_state;
    logic [SLOT_BITS-1:0]  r_cur, n_cur;
    t_ctl                  r_head, n_head;
    logic [SLOT_BITS-1:0]  r_res_task, n_res_task;
    logic                  r_res_sw, n_res_sw;
    logic                  r_res_sch, n_res_sch;
    logic                  r_res_idle, n_res_idle;
    logic                  r_out_valid, n_out_valid;
    logic [SLOT_BITS-1:0]  r_out_task, n_out_task;
    logic                  r_out_sw, n_out_sw;
    logic                  r_out_sch, n_out_sch;
    logic                  r_out_idle, n_out_idle;

    t_op                   w_op;
    logic                  w_out_free;
    logic                  w_in_accept;
    logic                  w_in_range;
    t_wr                   w_wr;
    logic [SLOT_BITS-1:0]  w_wr_slot;
    logic [COUNT_BITS-1:0] w_wr_priority;
    logic [COUNT_BITS-1:0] w_wr_counter;
    t_ctl                  w_tail_ctl;
    logic [COUNT_BITS-1:0] w_tail_best;
    logic [SLOT_BITS-1:0]  w_tail_pick;

    assign w_op        = t_op'(i_operation);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !(r_state == S_IDLE && w_out_free);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_in_range  = (32'(i_slot) < SLOTS);

    // Slot updates go straight to the addressed cell at the accept edge.
    assign w_wr.en       = w_in_accept && w_in_range && (w_op == OP_WRITE || w_op == OP_SETRUN);
    assign w_wr.full     = (w_op == OP_WRITE);
    assign w_wr.present  = i_present;
    assign w_wr.runnable = i_runnable;
    assign w_wr_slot     = SLOT_BITS'(i_slot);
    assign w_wr_priority = COUNT_BITS'(i_priority_req);
    assign w_wr_counter  = COUNT_BITS'(i_counter);

    // The head packet starts every scan with no candidate.
    assign w_ctl[0]  = r_head;
    assign w_best[0] = '0;
    assign w_pick[0] = '0;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            cpts_cell #(
                .IDX        (g),
                .SLOT_BITS  (SLOT_BITS),
                .COUNT_BITS (COUNT_BITS)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_wr          (w_wr),
                .i_wr_slot     (w_wr_slot),
                .i_wr_priority (w_wr_priority),
                .i_wr_counter  (w_wr_counter),
                .i_cur         (r_cur),
                .i_ctl         (w_ctl[g]),
                .i_best        (w_best[g]),
                .i_pick        (w_pick[g]),
                .o_ctl         (w_ctl[g+1]),
                .o_best        (w_best[g+1]),
                .o_pick        (w_pick[g+1])
            );
        end
    endgenerate

    assign w_tail_ctl  = w_ctl[SLOTS];
    assign w_tail_best = w_best[SLOTS];
    assign w_tail_pick = w_pick[SLOTS];

    // Pass sequencing. The current index only moves when a pass finishes, so the tick
    // pass always sees a stable target slot.
    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_head      = '0;
        n_res_task  = r_res_task;
        n_res_sw    = r_res_sw;
        n_res_sch   = r_res_sch;
        n_res_idle  = r_res_idle;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_task  = r_out_task;
        n_out_sw    = r_out_sw;
        n_out_sch   = r_out_sch;
        n_out_idle  = r_out_idle;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    unique case (w_op) inside
                        OP_WRITE, OP_SETRUN: begin
                            n_out_valid = 1'b1;
                            n_out_task  = r_cur;
                            n_out_sw    = 1'b0;
                            n_out_sch   = 1'b0;
                            n_out_idle  = 1'b0;
                        end
                        OP_TICK: begin
                            n_head.valid = 1'b1;
                            n_head.mode  = PASS_TICK;
                            n_head.user  = i_user_mode;
                            n_state      = S_TICK;
                        end
                        default: begin
                            n_head.valid = 1'b1;
                            n_head.mode  = PASS_SCAN;
                            n_state      = S_SCAN;
                        end
                    endcase
                end
            end
            S_TICK: begin
                if (w_tail_ctl.valid) begin
                    if (w_tail_ctl.hit) begin
                        n_head.valid = 1'b1;
                        n_head.mode  = PASS_SCAN;
                        n_state      = S_SCAN;
                    end else begin
                        n_res_task = r_cur;
                        n_res_sw   = 1'b0;
                        n_res_sch  = 1'b0;
                        n_res_idle = 1'b0;
                        n_state    = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (w_tail_ctl.valid) begin
                    if (w_tail_best != '0) begin
                        n_cur      = w_tail_pick;
                        n_res_task = w_tail_pick;
                        n_res_sw   = (w_tail_pick != r_cur);
                        n_res_sch  = 1'b1;
                        n_res_idle = 1'b0;
                        n_state    = S_DONE;
                    end else begin
                        // Nothing left to run: reload the counter of every present slot and scan again.
                        n_head.valid = 1'b1;
                        n_head.mode  = PASS_RELOAD;
                        n_state      = S_RELOAD;
                    end
                end
            end
            S_RELOAD: begin
                if (w_tail_ctl.valid) begin
                    n_res_sch = 1'b1;
                    n_state   = S_DONE;
                    if (w_tail_best != '0) begin
                        n_cur      = w_tail_pick;
                        n_res_task = w_tail_pick;
                        n_res_sw   = (w_tail_pick != r_cur);
                        n_res_idle = 1'b0;
                    end else begin
                        // Still nothing runnable: fall back to slot 0 as the idle task.
                        n_cur      = '0;
                        n_res_task = '0;
                        n_res_sw   = (r_cur != '0);
                        n_res_idle = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_task  = r_res_task;
                    n_out_sw    = r_res_sw;
                    n_out_sch   = r_res_sch;
                    n_out_idle  = r_res_idle;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_head      <= n_head;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_task <= n_res_task;
        r_res_sw   <= n_res_sw;
        r_res_sch  <= n_res_sch;
        r_res_idle <= n_res_idle;
        r_out_task <= n_out_task;
        r_out_sw   <= n_out_sw;
        r_out_sch  <= n_out_sch;
        r_out_idle <= n_out_idle;
    end

    assign o_out_valid     = r_out_valid;
    assign o_current_task  = TASK_FIELD_W'(r_out_task);
    assign o_switched      = r_out_sw;
    assign o_scheduled     = r_out_sch;
    assign o_idle_fallback = r_out_idle;

    // The idle fallback only comes out of a scheduling pass and always lands on slot 0.
    a_idle_is_slot0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_idle) |-> (r_out_sch && r_out_task == '0))
        else $error("idle fallback without a pass or away from slot 0");

    // Without a pass the current task cannot move.
    a_no_switch_unscheduled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_sch) |-> !r_out_sw)
        else $error("task switched without a scheduling pass");

    // A packet only comes back while the controller is waiting for one.
    a_tail_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail_ctl.valid |-> (r_state == S_TICK || r_state == S_SCAN || r_state == S_RELOAD))
        else $error("packet left the chain while no pass was pending");

    // Slot updates answer on the next cycle.
    a_write_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && (w_op == OP_WRITE || w_op == OP_SETRUN)) |=> (r_out_valid && !r_out_sch))
        else $error("slot update did not produce its result word");

    // The current index holds while a tick pass is in flight.
    a_cur_stable_in_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK && !w_tail_ctl.valid) |=> $stable(r_cur))
        else $error("current index moved during a tick pass");

endmodule
